[rtl/core/epd_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// epd_pkg
// Widths, register indexes, line positions and result layout shared by the
// edge pulse timing decoder and its checker.
// ----------------------------------------------------------------------------
package epd_pkg;

   localparam int SAMPLE_W  = 8;
   localparam int PERIOD_W  = 20;
   localparam int TIME_W    = 34;
   localparam int CNT_W     = 14;
   localparam int AVG_W     = 32;
   localparam int MASK_W    = 4;
   localparam int LINE_IDX_W = $clog2(SAMPLE_W);

   localparam logic [TIME_W-1:0] T34_MAX = {TIME_W{1'b1}};
   localparam logic [CNT_W-1:0]  CNT_MAX = {CNT_W{1'b1}};

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_ROLE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FWD_SEL = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD  = 2'd2;

   // physical line positions within a sample
   localparam logic [LINE_IDX_W-1:0] LINE_INIT_DATA = 3'd0;
   localparam logic [LINE_IDX_W-1:0] LINE_INIT_CLK  = 3'd1;
   localparam logic [LINE_IDX_W-1:0] LINE_INIT_SEL  = 3'd2;
   localparam logic [LINE_IDX_W-1:0] LINE_RESP_SEL  = 3'd3;
   localparam logic [LINE_IDX_W-1:0] LINE_RESP_CLK  = 3'd4;
   localparam logic [LINE_IDX_W-1:0] LINE_RESP_DATA = 3'd5;

   // found mask bits
   localparam int FOUND_CLK_TX  = 0;
   localparam int FOUND_CLK_RX  = 1;
   localparam int FOUND_DAT_TX  = 2;
   localparam int FOUND_DAT_RX  = 3;

   // result layout in rsp_tdata, lowest bit up
   localparam int RSP_MASK_LO    = 0;
   localparam int RSP_CLK_TX_LO  = RSP_MASK_LO + MASK_W;
   localparam int RSP_CLK_RX_LO  = RSP_CLK_TX_LO + TIME_W;
   localparam int RSP_DAT_TX_LO  = RSP_CLK_RX_LO + TIME_W;
   localparam int RSP_DAT_RX_LO  = RSP_DAT_TX_LO + TIME_W;
   localparam int RSP_CLK_HI_LO  = RSP_DAT_RX_LO + TIME_W;
   localparam int RSP_CLK_LO_LO  = RSP_CLK_HI_LO + AVG_W;
   localparam int RSP_DAT_HI_LO  = RSP_CLK_LO_LO + AVG_W;
   localparam int RSP_DAT_CNT_LO = RSP_DAT_HI_LO + AVG_W;
   localparam int RSP_CLK_HCNT_LO = RSP_DAT_CNT_LO + CNT_W;
   localparam int RSP_CLK_LCNT_LO = RSP_CLK_HCNT_LO + CNT_W;
   localparam int RSP_USED_W     = RSP_CLK_LCNT_LO + CNT_W;
   localparam int RSP_DATA_W     = ((RSP_USED_W + 7) / 8) * 8;

   // divider: dividend is a saturated sum plus half the count
   localparam int DIVD_W    = TIME_W + 1;
   localparam int DIV_CNT_W = $clog2(DIVD_W + 1);

endpackage : epd_pkg
`default_nettype wire

[rtl/core/edge_pulse_timing_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// edge_pulse_timing_decoder
// Finds edges on a forward line and a data line of captured samples, keeps
// first-edge times and pulse width sums, and reports times, averages and pulse counts per capture.
// ----------------------------------------------------------------------------
//
//  channel  dir  handshake              payload
//  -------  ---  ---------------------  -------------------------------------
//  req      in   req_tvalid/req_tready  tdata: sample; tlast: last_sample
//  rsp      out  rsp_tvalid/rsp_tready  tdata: mask, 4 times, 3 avgs, 3 counts
//  csr      in   csr_we                 csr_index, csr_wdata
//
//  A sample passes through accept, forward leg, data leg and time advance; the
//  last three steps use the one shared 34-bit add/subtract/saturate unit.
//  A last sample then works out the three rounded averages (each one rounding add
//  in the shared unit, then a one-bit-a-step restoring divider) and the load
//  of the result register. Reset is synchronous and clears the capture state
//  and configuration; edge flags, divider, averages and result data are not reset.
//  The result register frees the core: further samples are taken while a
//  result waits; only the next result load waits on rsp_tready.
//
module edge_pulse_timing_decoder
   import epd_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // slave side
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [SAMPLE_W-1:0]   req_tdata,   // [7:0] sample
   input  wire logic                  req_tlast,   // last_sample
   // master side
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // hit mask, clock_tx_time,
                                                   // clock_rx_time, data_tx_time,
                                                   // data_rx_time, clock_high_avg,
                                                   // clock_low_avg, data_high_avg,
                                                   // data pulses,
                                                   // clock_high_pulses,
                                                   // clock_low_pulses, zero pad
   // configuration
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [PERIOD_W-1:0]   csr_wdata
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_FWD  = 3'd1;
   localparam logic [2:0] S_DAT  = 3'd2;
   localparam logic [2:0] S_TIME = 3'd3;
   localparam logic [2:0] S_RND  = 3'd4;
   localparam logic [2:0] S_DIV  = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   localparam logic [1:0] AVG_CLK_HI = 2'd0;
   localparam logic [1:0] AVG_CLK_LO = 2'd1;
   localparam logic [1:0] AVG_DAT_HI = 2'd2;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
      sat_inc = (c == CNT_MAX) ? CNT_MAX : c + 1'b1;
   endfunction

   // configuration registers
   logic                role_ff;
   logic                fwd_sel_ff;
   logic [PERIOD_W-1:0] period_ff;

   // sequencer and capture state
   logic [2:0]          state_ff, state_in;
   logic [SAMPLE_W-1:0] prior_ff, prior_in;
   logic                primed_ff, primed_in;
   logic [TIME_W-1:0]   now_ff, now_in;
   logic [MASK_W-1:0]   found_ff, found_in;
   logic [TIME_W-1:0]   first_ff [MASK_W];
   logic [TIME_W-1:0]   first_in [MASK_W];
   logic [TIME_W-1:0]   fwd_rise_t_ff, fwd_rise_t_in;
   logic [TIME_W-1:0]   fwd_fall_t_ff, fwd_fall_t_in;
   logic [1:0]          fwd_flags_ff, fwd_flags_in;  // bit 0 have rise, bit 1 have fall
   logic [TIME_W-1:0]   fwd_hi_sum_ff, fwd_hi_sum_in;
   logic [TIME_W-1:0]   fwd_lo_sum_ff, fwd_lo_sum_in;
   logic [CNT_W-1:0]    fwd_hi_cnt_ff, fwd_hi_cnt_in;
   logic [CNT_W-1:0]    fwd_lo_cnt_ff, fwd_lo_cnt_in;
   logic [TIME_W-1:0]   dat_rise_t_ff, dat_rise_t_in;
   logic                dat_open_ff, dat_open_in;
   logic [TIME_W-1:0]   dat_sum_ff, dat_sum_in;
   logic [CNT_W-1:0]    dat_cnt_ff, dat_cnt_in;

   // per-sample edge flags: fwd rise, fwd fall, data rise, data fall
   logic                fr_ff, ff_ff, dr_ff, df_ff;
   logic                fr_in, ff_in, dr_in, df_in;
   logic                last_ff, last_in;

   // averaging
   logic [1:0]          avg_sel_ff, avg_sel_in;
   logic [DIVD_W-1:0]   div_q_ff, div_q_in;
   logic [CNT_W-1:0]    div_r_ff, div_r_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [AVG_W-1:0]    avg_ff [3];
   logic [AVG_W-1:0]    avg_in [3];

   // result register
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // shared unit
   logic [TIME_W-1:0]   unit_a, unit_b, unit_c;
   logic [TIME_W+1:0]   unit_raw;
   logic [TIME_W-1:0]   unit_sat;

   // edge detect and divider step
   logic [LINE_IDX_W-1:0] fwd_bit, dat_bit;
   logic [SAMPLE_W-1:0]   rising, falling;
   logic                  req_fire;
   logic [TIME_W-1:0]     sum_sel;
   logic [CNT_W-1:0]      cnt_sel;
   logic [CNT_W:0]        rem_shift;
   logic                  rem_ge;
   logic [DIVD_W-1:0]     quot;
   logic [AVG_W-1:0]      avg_val;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // configuration writes; an index beyond the list is dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         role_ff    <= 1'b0;
         fwd_sel_ff <= 1'b0;
         period_ff  <= PERIOD_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ROLE:    role_ff    <= csr_wdata[0];
            CSR_FWD_SEL: fwd_sel_ff <= csr_wdata[0];
            CSR_PERIOD:  period_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // line selection from role and signal group
   always_comb begin
      if (role_ff) begin
         fwd_bit = fwd_sel_ff ? LINE_RESP_SEL : LINE_RESP_CLK;
         dat_bit = LINE_RESP_DATA;
      end else begin
         fwd_bit = fwd_sel_ff ? LINE_INIT_SEL : LINE_INIT_CLK;
         dat_bit = LINE_INIT_DATA;
      end
      rising  = req_tdata & ~prior_ff;
      falling = prior_ff & ~req_tdata;
   end

   // pick the sum and count for the average being worked on
   always_comb begin
      unique case (avg_sel_ff)
         AVG_CLK_HI: begin
            sum_sel = fwd_hi_sum_ff;
            cnt_sel = fwd_hi_cnt_ff;
         end
         AVG_CLK_LO: begin
            sum_sel = fwd_lo_sum_ff;
            cnt_sel = fwd_lo_cnt_ff;
         end
         default: begin
            sum_sel = dat_sum_ff;
            cnt_sel = dat_cnt_ff;
         end
      endcase
   end

   // shared unit: a + b - c, with a 34-bit saturated copy; c never exceeds a + b
   always_comb begin
      unit_a = now_ff;
      unit_b = TIME_W'(period_ff);
      unit_c = '0;
      unique case (state_ff)
         S_FWD: begin
            unit_a = fr_ff ? fwd_lo_sum_ff : fwd_hi_sum_ff;
            unit_b = now_ff;
            unit_c = fr_ff ? fwd_fall_t_ff : fwd_rise_t_ff;
         end
         S_DAT: begin
            unit_a = dat_sum_ff;
            unit_b = now_ff;
            unit_c = dat_rise_t_ff;
         end
         S_RND: begin
            unit_a = sum_sel;
            unit_b = TIME_W'(cnt_sel[CNT_W-1:1]);
         end
         default: ;
      endcase
      unit_raw = {2'b00, unit_a} + {2'b00, unit_b} - {2'b00, unit_c};
      unit_sat = (unit_raw > {2'b00, T34_MAX}) ? T34_MAX : unit_raw[TIME_W-1:0];
   end

   // restoring divider step, one quotient bit per cycle
   always_comb begin
      rem_shift = {div_r_ff, div_q_ff[DIVD_W-1]};
      rem_ge    = (rem_shift >= {1'b0, cnt_sel});
      quot      = {div_q_ff[DIVD_W-2:0], rem_ge};
      if (cnt_sel == '0) begin
         avg_val = '0;
      end else if (quot[DIVD_W-1:AVG_W] != '0) begin
         avg_val = {AVG_W{1'b1}};
      end else begin
         avg_val = quot[AVG_W-1:0];
      end
   end

   // sequencer
   always_comb begin
      state_in      = state_ff;
      prior_in      = prior_ff;
      primed_in     = primed_ff;
      now_in        = now_ff;
      found_in      = found_ff;
      first_in      = first_ff;
      fwd_rise_t_in = fwd_rise_t_ff;
      fwd_fall_t_in = fwd_fall_t_ff;
      fwd_flags_in  = fwd_flags_ff;
      fwd_hi_sum_in = fwd_hi_sum_ff;
      fwd_lo_sum_in = fwd_lo_sum_ff;
      fwd_hi_cnt_in = fwd_hi_cnt_ff;
      fwd_lo_cnt_in = fwd_lo_cnt_ff;
      dat_rise_t_in = dat_rise_t_ff;
      dat_open_in   = dat_open_ff;
      dat_sum_in    = dat_sum_ff;
      dat_cnt_in    = dat_cnt_ff;
      fr_in         = fr_ff;
      ff_in         = ff_ff;
      dr_in         = dr_ff;
      df_in         = df_ff;
      last_in       = last_ff;
      avg_sel_in    = avg_sel_ff;
      div_q_in      = div_q_ff;
      div_r_in      = div_r_ff;
      div_cnt_in    = div_cnt_ff;
      avg_in        = avg_ff;
      rsp_data_in   = rsp_data_ff;
      // drop the result once the sink takes it
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               // the first sample of a capture only primes the comparison
               fr_in     = primed_ff && rising[fwd_bit];
               ff_in     = primed_ff && falling[fwd_bit];
               dr_in     = primed_ff && rising[dat_bit];
               df_in     = primed_ff && falling[dat_bit];
               last_in   = req_tlast;
               prior_in  = req_tdata;
               primed_in = 1'b1;
               state_in  = S_FWD;
            end
         end

         S_FWD: begin
            if (fr_ff) begin
               // close a low pulse, then open a high pulse
               if (fwd_flags_ff[1]) begin
                  fwd_lo_sum_in = unit_sat;
                  fwd_lo_cnt_in = sat_inc(fwd_lo_cnt_ff);
               end
               fwd_rise_t_in = now_ff;
               fwd_flags_in  = 2'b01;
            end else if (ff_ff && fwd_flags_ff[0]) begin
               fwd_fall_t_in   = now_ff;
               fwd_flags_in[1] = 1'b1;
               fwd_hi_sum_in   = unit_sat;
               fwd_hi_cnt_in   = sat_inc(fwd_hi_cnt_ff);
            end
            // first-edge times for the active role
            if (role_ff) begin
               if (fr_ff && !found_ff[FOUND_CLK_RX]) begin
                  first_in[FOUND_CLK_RX] = now_ff;
                  found_in[FOUND_CLK_RX] = 1'b1;
               end
               if (dr_ff && !found_ff[FOUND_DAT_TX]) begin
                  first_in[FOUND_DAT_TX] = now_ff;
                  found_in[FOUND_DAT_TX] = 1'b1;
               end
            end else begin
               if (fr_ff && !found_ff[FOUND_CLK_TX]) begin
                  first_in[FOUND_CLK_TX] = now_ff;
                  found_in[FOUND_CLK_TX] = 1'b1;
               end
               if (dr_ff && !found_ff[FOUND_DAT_RX]) begin
                  first_in[FOUND_DAT_RX] = now_ff;
                  found_in[FOUND_DAT_RX] = 1'b1;
               end
            end
            state_in = S_DAT;
         end

         S_DAT: begin
            if (dr_ff) begin
               dat_rise_t_in = now_ff;
               dat_open_in   = 1'b1;
            end else if (df_ff && dat_open_ff) begin
               dat_sum_in  = unit_sat;
               dat_cnt_in  = sat_inc(dat_cnt_ff);
               dat_open_in = 1'b0;
            end
            state_in = S_TIME;
         end

         S_TIME: begin
            // advance the sample clock
            now_in     = unit_sat;
            avg_sel_in = AVG_CLK_HI;
            state_in   = last_ff ? S_RND : S_IDLE;
         end

         S_RND: begin
            // rounding add, then start the divider
            div_q_in   = unit_raw[DIVD_W-1:0];
            div_r_in   = '0;
            div_cnt_in = DIV_CNT_W'(DIVD_W);
            state_in   = S_DIV;
         end

         S_DIV: begin
            div_q_in   = quot;
            div_r_in   = rem_ge ? CNT_W'(rem_shift - {1'b0, cnt_sel})
                                : rem_shift[CNT_W-1:0];
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(1)) begin
               avg_in[avg_sel_ff] = avg_val;
               if (avg_sel_ff == AVG_DAT_HI) begin
                  state_in = S_DONE;
               end else begin
                  avg_sel_in = avg_sel_ff + 1'b1;
                  state_in   = S_RND;
               end
            end
         end

         S_DONE: begin
            // hold until the result register is free, then load and clear
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({fwd_lo_cnt_ff, fwd_hi_cnt_ff, dat_cnt_ff,
                                           avg_ff[AVG_DAT_HI], avg_ff[AVG_CLK_LO],
                                           avg_ff[AVG_CLK_HI],
                                           first_ff[FOUND_DAT_RX], first_ff[FOUND_DAT_TX],
                                           first_ff[FOUND_CLK_RX], first_ff[FOUND_CLK_TX],
                                           found_ff});
               prior_in      = '0;
               primed_in     = 1'b0;
               now_in        = '0;
               found_in      = '0;
               for (int i = 0; i < MASK_W; i++) begin
                  first_in[i] = '0;
               end
               fwd_rise_t_in = '0;
               fwd_fall_t_in = '0;
               fwd_flags_in  = '0;
               fwd_hi_sum_in = '0;
               fwd_lo_sum_in = '0;
               fwd_hi_cnt_in = '0;
               fwd_lo_cnt_in = '0;
               dat_rise_t_in = '0;
               dat_open_in   = 1'b0;
               dat_sum_in    = '0;
               dat_cnt_in    = '0;
               state_in      = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // capture state and control
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_valid_ff  <= 1'b0;
         prior_ff      <= '0;
         primed_ff     <= 1'b0;
         now_ff        <= '0;
         found_ff      <= '0;
         for (int i = 0; i < MASK_W; i++) begin
            first_ff[i] <= '0;
         end
         fwd_rise_t_ff <= '0;
         fwd_fall_t_ff <= '0;
         fwd_flags_ff  <= '0;
         fwd_hi_sum_ff <= '0;
         fwd_lo_sum_ff <= '0;
         fwd_hi_cnt_ff <= '0;
         fwd_lo_cnt_ff <= '0;
         dat_rise_t_ff <= '0;
         dat_open_ff   <= 1'b0;
         dat_sum_ff    <= '0;
         dat_cnt_ff    <= '0;
         avg_sel_ff    <= AVG_CLK_HI;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         prior_ff      <= prior_in;
         primed_ff     <= primed_in;
         now_ff        <= now_in;
         found_ff      <= found_in;
         first_ff      <= first_in;
         fwd_rise_t_ff <= fwd_rise_t_in;
         fwd_fall_t_ff <= fwd_fall_t_in;
         fwd_flags_ff  <= fwd_flags_in;
         fwd_hi_sum_ff <= fwd_hi_sum_in;
         fwd_lo_sum_ff <= fwd_lo_sum_in;
         fwd_hi_cnt_ff <= fwd_hi_cnt_in;
         fwd_lo_cnt_ff <= fwd_lo_cnt_in;
         dat_rise_t_ff <= dat_rise_t_in;
         dat_open_ff   <= dat_open_in;
         dat_sum_ff    <= dat_sum_in;
         dat_cnt_ff    <= dat_cnt_in;
         avg_sel_ff    <= avg_sel_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      fr_ff       <= fr_in;
      ff_ff       <= ff_in;
      dr_ff       <= dr_in;
      df_ff       <= df_in;
      last_ff     <= last_in;
      div_q_ff    <= div_q_in;
      div_r_ff    <= div_r_in;
      div_cnt_ff  <= div_cnt_in;
      avg_ff      <= avg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule : edge_pulse_timing_decoder
`default_nettype wire

[rtl/core/epd_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// epd_checker
// Port-level checks for the edge pulse timing decoder, bound to its top level.
// ----------------------------------------------------------------------------
module epd_checker
   import epd_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_tvalid,
   input wire logic                  req_tready,
   input wire logic                  req_tlast,
   input wire logic                  rsp_tvalid,
   input wire logic                  rsp_tready,
   input wire logic [RSP_DATA_W-1:0] rsp_tdata
);

   // an accepted sample keeps the core busy, so input ready drops after it
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after a sample transaction");

   // a non-last sample never raises a result in the next cycle
   a_no_result_mid_capture: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && !req_tlast |=> !$rose(rsp_tvalid))
      else $error("result raised right after a non-last sample");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // the clock tx time reads zero when its mask bit is clear
   a_mask_time: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[RSP_MASK_LO + FOUND_CLK_TX]
      |-> rsp_tdata[RSP_CLK_TX_LO +: TIME_W] == '0)
      else $error("clock tx time set without its mask bit");

   // no measured clock high width means a zero clock high average
   a_zero_count_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[RSP_CLK_HCNT_LO +: CNT_W] == '0
      |-> rsp_tdata[RSP_CLK_HI_LO +: AVG_W] == '0)
      else $error("clock high average set with zero count");

endmodule : epd_checker

bind edge_pulse_timing_decoder epd_checker u_epd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire
